// ----- sv/bfp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfp_pkg: shared types and constants for the bit field packer
// Word formats for the element and packed byte channels and a small helper.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  localparam logic [3:0] WIDTH_RESET = 4'd8;

  typedef struct packed {
    logic [7:0] element;
    logic       is_last;
  } item_word_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_last;
  } pack_word_t;

  // Mask of the low n bits, n from 0 to 8.
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [8:0] m;
    m = (9'h001 << n) - 9'h001;
    return m[7:0];
  endfunction

endpackage

// ----- sv/bit_field_packer_top.sv -----
// ----------------------------------------------------------------------------
// bit_field_packer_top: variable-width MSB-first bit packer
// Each byte an element completes is written into the output queue and is
// offered once the bytes ahead of it are taken; a flushed second byte follows it.
// Throughput: one element per cycle while at least two queue slots are free; an
// element that closes a byte and flushes a partial one yields two bytes.
// Reset (synchronous, rst high) empties the output queue, clears the pending
// bits and sets field_width back to 8.
// ----------------------------------------------------------------------------
module bit_field_packer_top
  import bfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       field_width_we,
  input  logic [3:0] field_width_wdata,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_word_t item,
  output logic       pack_valid,
  input  logic       pack_ready,
  output pack_word_t pack
);

  // Configuration register. Values outside 1..8 are clamped on use.
  logic [3:0] field_width;

  // Packer state: bits not yet emitted, right-aligned, and how many are valid.
  logic [6:0] pending_bits;
  logic [2:0] pending_count;

  // Output queue. Each accepted word pushes up to two bytes, so a word is
  // only taken while at least two slots are free.
  pack_word_t       queue [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic       item_acc;
  logic       pack_acc;
  logic [3:0] eff_width;
  logic [7:0] val;
  logic [7:0] pend_mask;
  logic [6:0] pend_masked;
  logic [14:0] acc;
  logic [3:0] total;
  logic       full;
  logic [2:0] rem;
  logic [14:0] shifted;
  logic [7:0] full_byte;
  logic [7:0] rem_mask;
  logic [6:0] rem_bits;
  logic [15:0] flush_wide;
  logic [7:0] flush_byte;
  logic [1:0] n_push;
  pack_word_t res0;
  pack_word_t res1;

  assign item_acc   = item_valid & item_ready;
  assign pack_acc   = pack_valid & pack_ready;
  assign item_ready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign pack_valid = (count != '0);
  assign pack       = queue[rd_ptr];

  // Datapath: append the new field to the pending bits, cut off a full byte
  // if there is one, and on the last element flush the remainder padded with
  // zeros on the right.
  always_comb begin
    if (field_width == 4'd0) begin
      eff_width = 4'd1;
    end else if (field_width > 4'd8) begin
      eff_width = 4'd8;
    end else begin
      eff_width = field_width;
    end

    val         = item.element & low_mask(eff_width);
    pend_mask   = low_mask({1'b0, pending_count});
    pend_masked = pending_bits & pend_mask[6:0];
    acc         = ({8'b0, pend_masked} << eff_width) | {7'b0, val};
    total       = {1'b0, pending_count} + eff_width;

    // Total is at most 15, so bit 3 tells a full byte and the low bits are
    // the count left over either way.
    full      = total[3];
    rem       = total[2:0];
    shifted   = acc >> rem;
    full_byte = shifted[7:0];
    rem_mask  = low_mask({1'b0, rem});
    rem_bits  = acc[6:0] & rem_mask[6:0];

    flush_wide = {9'b0, rem_bits} << (4'd8 - {1'b0, rem});
    flush_byte = flush_wide[7:0];

    res1.packed_byte = flush_byte;
    res1.byte_last   = 1'b1;

    if (full) begin
      res0.packed_byte = full_byte;
      res0.byte_last   = item.is_last & (rem == 3'd0);
      n_push = (item.is_last && rem != 3'd0) ? 2'd2 : 2'd1;
    end else begin
      res0   = res1;
      n_push = item.is_last ? 2'd1 : 2'd0;
    end
  end

  always_comb begin
    count_next = count;
    if (item_acc) begin
      count_next = count_next + CNT_W'(n_push);
    end
    if (pack_acc) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width   <= WIDTH_RESET;
      pending_bits  <= '0;
      pending_count <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (field_width_we) begin
        field_width <= field_width_wdata;
      end
      if (item_acc) begin
        if (item.is_last) begin
          pending_bits  <= '0;
          pending_count <= '0;
        end else begin
          pending_bits  <= rem_bits;
          pending_count <= rem;
        end
        wr_ptr <= wr_ptr + PTR_W'(n_push);
      end
      if (pack_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage holds payload only; occupancy lives in the count.
  always_ff @(posedge clk) begin
    if (item_acc && n_push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (item_acc && n_push == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

endmodule

// ----- sv/bfp_checker.sv -----
// ----------------------------------------------------------------------------
// bfp_checker: port-level checks for the bit field packer
// Watches the handshakes of the top level and flags illegal sequences.
// ----------------------------------------------------------------------------
module bfp_checker
  import bfp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input item_word_t item,
  input logic       pack_valid,
  input logic       pack_ready,
  input pack_word_t pack
);

  // A byte that is offered and not taken stays offered and unchanged.
  a_pack_hold: assert property (@(posedge clk) disable iff (rst)
    pack_valid && !pack_ready |=> pack_valid && $stable(pack))
    else $error("packed byte dropped or changed while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !pack_valid)
    else $error("byte offered right after reset");

  // With no byte waiting, the packer must be able to take a word.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !pack_valid |-> item_ready)
    else $error("packer stalled with an empty output");

  // The last element always yields at least one byte.
  a_last_output: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.is_last |=> pack_valid)
    else $error("last element produced no byte");

endmodule

bind bit_field_packer_top bfp_checker u_bfp_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .pack_valid (pack_valid),
  .pack_ready (pack_ready),
  .pack       (pack)
);
